>>> design/tqle_pkg.sv
// ----------------------------------------------------------------------------
// tqle_pkg
// Shared types and constants for the tabular Q-learning engine.
// ----------------------------------------------------------------------------
package tqle_pkg;

    localparam int CFG_W   = 17;
    localparam int CFG_IW  = 3;
    localparam int ONE_Q16 = 65536;

    localparam logic [2:0] CMD_SELECT = 3'd0;
    localparam logic [2:0] CMD_UPDATE = 3'd1;
    localparam logic [2:0] CMD_DECAY  = 3'd2;
    localparam logic [2:0] CMD_READ   = 3'd3;
    localparam logic [2:0] CMD_WRITE  = 3'd4;

    localparam logic [CFG_IW-1:0] REG_EPS_INIT  = 3'd0;
    localparam logic [CFG_IW-1:0] REG_ALPHA     = 3'd1;
    localparam logic [CFG_IW-1:0] REG_GAMMA     = 3'd2;
    localparam logic [CFG_IW-1:0] REG_DECAY     = 3'd3;
    localparam logic [CFG_IW-1:0] REG_EPS_FLOOR = 3'd4;

    localparam logic [CFG_W-1:0] RST_EPS_INIT  = 17'd6554;
    localparam logic [CFG_W-1:0] RST_ALPHA     = 17'd6554;
    localparam logic [CFG_W-1:0] RST_GAMMA     = 17'd58982;
    localparam logic [CFG_W-1:0] RST_DECAY     = 17'd64880;
    localparam logic [CFG_W-1:0] RST_EPS_FLOOR = 17'd655;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [14:0]        board_key;
        logic [3:0]         act;
        logic [14:0]        next_board_key;
        logic [8:0]         avail_mask;
        logic signed [31:0] reward;
        logic signed [31:0] q_in;
        logic [15:0]        rand_threshold;
        logic [15:0]        rand_pick;
    } req_t;

    typedef struct packed {
        logic [3:0]         chosen_action;
        logic signed [31:0] q_out;
        logic               explored;
        logic               status;
    } rsp_t;

endpackage

>>> design/tqle_ram.sv
// ----------------------------------------------------------------------------
// tqle_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tqle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/tqle_mod.sv
// ----------------------------------------------------------------------------
// tqle_mod
// Bit-serial remainder unit: 16-bit dividend modulo a small divisor.
// ----------------------------------------------------------------------------
module tqle_mod (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [3:0]  divisor,
    output logic        busy,
    output logic [3:0]  rem
);

    logic [4:0]  cnt_reg;
    logic        run_reg;
    logic [3:0]  rem_reg;
    logic [15:0] sh_reg;
    logic [3:0]  div_reg;
    logic [4:0]  trial;
    logic [3:0]  rem_next;

    always_comb
    begin
        trial = {rem_reg, sh_reg[15]};
        if (trial >= {1'b0, div_reg})
        begin
            rem_next = 4'(trial - {1'b0, div_reg});
        end
        else
        begin
            rem_next = trial[3:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (start)
        begin
            run_reg <= 1'b1;
            cnt_reg <= 5'd16;
            rem_reg <= '0;
            sh_reg  <= dividend;
            div_reg <= divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            sh_reg  <= {sh_reg[14:0], 1'b0};
            cnt_reg <= cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                run_reg <= 1'b0;
            end
        end
    end

    assign busy = run_reg;
    assign rem  = rem_reg;

endmodule

>>> design/tabular_q_learning_engine_core.sv
// ----------------------------------------------------------------------------
// tabular_q_learning_engine_core
// Q table engine: epsilon-greedy select, Q update, decay, read and write.
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// req       in         req_valid / req_stall  tqle_pkg::req_t
// rsp       out        rsp_valid / rsp_stall  tqle_pkg::rsp_t
// cfg       in         cfg_we                 cfg_index, cfg_wdata
//
// One request at a time. Update reads one table entry per action of the next
// board through the single RAM read port, then the entry being updated, then
// runs the multiply chain and one write; explore waits on the remainder unit
// and then walks the mask to the chosen free action.
// After reset all NUM_BOARDS*NUM_ACTIONS entries are cleared, one entry per
// cycle, with req_stall high. A held result does not block the next request.
// ----------------------------------------------------------------------------
module tabular_q_learning_engine_core #(
    parameter int NUM_BOARDS  = 19683,
    parameter int NUM_ACTIONS = 9,
    parameter int Q_WIDTH     = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  tqle_pkg::req_t                  req,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output tqle_pkg::rsp_t                  rsp,
    input  logic                            cfg_we,
    input  logic [tqle_pkg::CFG_IW-1:0]     cfg_index,
    input  logic [tqle_pkg::CFG_W-1:0]      cfg_wdata
);

    import tqle_pkg::*;

    localparam int DEPTH = NUM_BOARDS * NUM_ACTIONS;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = ((Q_WIDTH > 32) ? Q_WIDTH : 32) + 24;
    localparam int PW    = Q_WIDTH + 18;
    localparam int DW    = Q_WIDTH + 1;
    localparam int PMW   = Q_WIDTH + 19;
    localparam int MW    = Q_WIDTH + 3;

    localparam logic signed [SW-1:0] QMAX =
        signed'({{(SW-Q_WIDTH+1){1'b0}}, {(Q_WIDTH-1){1'b1}}});
    localparam logic signed [SW-1:0] QMIN =
        signed'({{(SW-Q_WIDTH+1){1'b1}}, {(Q_WIDTH-1){1'b0}}});
    localparam logic signed [SW-1:0] I32_MAX = signed'({{(SW-31){1'b0}}, {31{1'b1}}});
    localparam logic signed [SW-1:0] I32_MIN = signed'({{(SW-31){1'b1}}, {31{1'b0}}});

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_MOD  = 4'd2;
    localparam logic [3:0] S_PICK = 4'd3;
    localparam logic [3:0] S_RDQ  = 4'd4;
    localparam logic [3:0] S_RDW  = 4'd5;
    localparam logic [3:0] S_SCAN = 4'd6;
    localparam logic [3:0] S_TAIL = 4'd7;
    localparam logic [3:0] S_GRD  = 4'd8;
    localparam logic [3:0] S_G1   = 4'd9;
    localparam logic [3:0] S_G2   = 4'd10;
    localparam logic [3:0] S_G3   = 4'd11;
    localparam logic [3:0] S_G4   = 4'd12;
    localparam logic [3:0] S_DEC  = 4'd13;
    localparam logic [3:0] S_WRC  = 4'd14;
    localparam logic [3:0] S_FIN  = 4'd15;

    function automatic logic signed [Q_WIDTH-1:0] sat_q(input logic signed [SW-1:0] v);
        if (v > QMAX)
        begin
            return Q_WIDTH'(QMAX);
        end
        if (v < QMIN)
        begin
            return Q_WIDTH'(QMIN);
        end
        return Q_WIDTH'(v);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [Q_WIDTH-1:0] v);
        logic signed [SW-1:0] e;
        e = SW'(v);
        if (e > I32_MAX)
        begin
            return 32'(I32_MAX);
        end
        if (e < I32_MIN)
        begin
            return 32'(I32_MIN);
        end
        return 32'(e);
    endfunction

    function automatic logic avail(input logic [8:0] m, input logic [3:0] a);
        logic [15:0] e;
        e = {7'd0, m};
        return ({28'd0, a} < NUM_ACTIONS) && e[a];
    endfunction

    function automatic logic entry_ok(input logic [14:0] key, input logic [3:0] a);
        return ({17'd0, key} < NUM_BOARDS) && ({28'd0, a} < NUM_ACTIONS);
    endfunction

    function automatic logic [AW-1:0] entry_addr(input logic [14:0] key, input logic [3:0] a);
        return AW'(key * NUM_ACTIONS + a);
    endfunction

    logic [3:0]  state_reg;
    logic [AW-1:0] clr_reg;
    req_t        req_reg;
    logic [CFG_W-1:0] eps_reg, alpha_reg, gamma_reg, decay_reg, floor_reg;
    logic [3:0]  scan_reg, seen_reg, pick_reg, actd_reg, bact_reg;
    logic        ok_reg, cmp_reg, avd_reg, have_reg;
    logic signed [Q_WIDTH-1:0] best_reg, cur_reg, gb_reg;
    logic signed [DW-1:0]      diff_reg;
    logic signed [MW-1:0]      m_reg;
    rsp_t        res_reg, rsp_reg;
    logic        rsp_valid_reg;

    logic [3:0]  cnt;
    logic        mod_start, mod_busy;
    logic [3:0]  mod_rem;
    logic [14:0] rd_key;
    logic [3:0]  rd_a;
    logic        ram_we;
    logic [AW-1:0] ram_waddr;
    logic [Q_WIDTH-1:0] ram_wdata, ram_rdata;
    logic signed [Q_WIDTH-1:0] rdq, rsat, qsat, tgt, newq;
    logic signed [17:0]  gfac, afac;
    logic signed [PW-1:0]  gprod;
    logic signed [PMW-1:0] mprod;
    logic [33:0] dprod;
    logic [CFG_W-1:0] cfg_val;
    logic req_take;
    logic empty_err;

    // active action count of the incoming request
    always_comb
    begin
        cnt = '0;
        for (int a = 0; a < 9; a++)
        begin
            if (a < NUM_ACTIONS)
            begin
                cnt = cnt + {3'd0, req.avail_mask[a]};
            end
        end
    end

    assign req_take  = req_valid && (state_reg == S_IDLE);
    assign req_stall = (state_reg != S_IDLE);
    assign mod_start = req_take && (req.cmd == CMD_SELECT) && (cnt != 4'd0)
                       && ({1'b0, req.rand_threshold} < eps_reg);
    assign empty_err = (cnt == 4'd0) && ((req.cmd == CMD_SELECT) || (req.cmd == CMD_UPDATE));

    tqle_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (req.rand_pick),
        .divisor  (cnt),
        .busy     (mod_busy),
        .rem      (mod_rem)
    );

    always_comb
    begin
        rd_key = req_reg.board_key;
        rd_a   = pick_reg;
        case (state_reg)
            S_SCAN:
            begin
                rd_key = (req_reg.cmd == CMD_UPDATE) ? req_reg.next_board_key
                                                     : req_reg.board_key;
                rd_a   = scan_reg;
            end
            S_TAIL:
            begin
                rd_a = req_reg.act;
            end
            default:
            begin
                rd_a = pick_reg;
            end
        endcase
    end

    assign rdq  = ok_reg ? signed'(ram_rdata) : '0;
    assign rsat = sat_q(SW'($signed(req_reg.reward)));
    assign qsat = sat_q(SW'($signed(req_reg.q_in)));
    assign gfac = signed'({1'b0, gamma_reg});
    assign afac = signed'({1'b0, alpha_reg});
    assign gprod = best_reg * gfac;
    assign tgt   = sat_q(SW'(rsat) + SW'(gb_reg));
    assign mprod = diff_reg * afac;
    assign newq  = sat_q(SW'(cur_reg) + SW'(m_reg));
    assign dprod = eps_reg * decay_reg;
    assign cfg_val = (cfg_wdata > CFG_W'(ONE_Q16)) ? CFG_W'(ONE_Q16) : cfg_wdata;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = entry_addr(req_reg.board_key, req_reg.act);
        ram_wdata = newq;
        case (state_reg)
            S_CLR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
            end
            S_G4:
            begin
                ram_we = entry_ok(req_reg.board_key, req_reg.act);
            end
            S_WRC:
            begin
                ram_we    = entry_ok(req_reg.board_key, req_reg.act);
                ram_wdata = qsat;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    tqle_ram #(
        .WIDTH (Q_WIDTH),
        .DEPTH (DEPTH)
    ) u_qram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (entry_addr(rd_key, rd_a)),
        .rdata (ram_rdata)
    );

    // payload pipeline of the table scan
    always_ff @(posedge clk)
    begin
        ok_reg   <= entry_ok(rd_key, rd_a);
        avd_reg  <= avail(req_reg.avail_mask, scan_reg);
        actd_reg <= scan_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            eps_reg       <= RST_EPS_INIT;
            alpha_reg     <= RST_ALPHA;
            gamma_reg     <= RST_GAMMA;
            decay_reg     <= RST_DECAY;
            floor_reg     <= RST_EPS_FLOOR;
            cmp_reg       <= 1'b0;
            have_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cmp_reg <= (state_reg == S_SCAN);
            if (cmp_reg && avd_reg && (!have_reg || (rdq > best_reg)))
            begin
                best_reg <= rdq;
                bact_reg <= actd_reg;
                have_reg <= 1'b1;
            end

            case (state_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        req_reg  <= req;
                        res_reg  <= '{chosen_action: 4'd0, q_out: 32'sd0,
                                      explored: mod_start, status: empty_err};
                        have_reg <= 1'b0;
                        scan_reg <= '0;
                        seen_reg <= '0;
                        pick_reg <= req.act;
                        case (req.cmd)
                            CMD_SELECT:
                            begin
                                if (cnt == 4'd0)
                                begin
                                    state_reg <= S_FIN;
                                end
                                else if (mod_start)
                                begin
                                    state_reg <= S_MOD;
                                end
                                else
                                begin
                                    state_reg <= S_SCAN;
                                end
                            end
                            CMD_UPDATE:
                            begin
                                if (cnt == 4'd0)
                                begin
                                    state_reg <= S_FIN;
                                end
                                else
                                begin
                                    state_reg <= S_SCAN;
                                end
                            end
                            CMD_DECAY: state_reg <= S_DEC;
                            CMD_READ:  state_reg <= S_RDQ;
                            CMD_WRITE: state_reg <= S_WRC;
                            default:   state_reg <= S_FIN;
                        endcase
                    end
                end
                S_MOD:
                begin
                    if (!mod_busy)
                    begin
                        state_reg <= S_PICK;
                    end
                end
                S_PICK:
                begin
                    // walk the mask until the k-th free action
                    scan_reg <= scan_reg + 4'd1;
                    if (avail(req_reg.avail_mask, scan_reg))
                    begin
                        if (seen_reg == mod_rem)
                        begin
                            pick_reg  <= scan_reg;
                            state_reg <= S_RDQ;
                        end
                        else
                        begin
                            seen_reg <= seen_reg + 4'd1;
                        end
                    end
                end
                S_RDQ:
                begin
                    state_reg <= S_RDW;
                end
                S_RDW:
                begin
                    res_reg.q_out <= sat32(rdq);
                    if (req_reg.cmd == CMD_SELECT)
                    begin
                        res_reg.chosen_action <= pick_reg;
                    end
                    state_reg <= S_FIN;
                end
                S_SCAN:
                begin
                    scan_reg <= scan_reg + 4'd1;
                    if (scan_reg == 4'(NUM_ACTIONS - 1))
                    begin
                        state_reg <= S_TAIL;
                    end
                end
                S_TAIL:
                begin
                    state_reg <= (req_reg.cmd == CMD_UPDATE) ? S_G1 : S_GRD;
                end
                S_GRD:
                begin
                    res_reg.chosen_action <= bact_reg;
                    res_reg.q_out         <= sat32(best_reg);
                    state_reg             <= S_FIN;
                end
                S_G1:
                begin
                    cur_reg   <= rdq;
                    gb_reg    <= sat_q(SW'(gprod >>> 16));
                    state_reg <= S_G2;
                end
                S_G2:
                begin
                    diff_reg  <= DW'(tgt) - DW'(cur_reg);
                    state_reg <= S_G3;
                end
                S_G3:
                begin
                    m_reg     <= MW'(mprod >>> 16);
                    state_reg <= S_G4;
                end
                S_G4:
                begin
                    res_reg.q_out <= sat32(newq);
                    state_reg     <= S_FIN;
                end
                S_DEC:
                begin
                    if (eps_reg >= floor_reg)
                    begin
                        eps_reg <= dprod[32:16];
                    end
                    state_reg <= S_FIN;
                end
                S_WRC:
                begin
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (!rsp_valid_reg || !rsp_stall)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if ((state_reg == S_FIN) && (!rsp_valid_reg || !rsp_stall))
            begin
                rsp_valid_reg <= 1'b1;
                rsp_reg       <= res_reg;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_EPS_INIT:
                    begin
                        eps_reg <= cfg_val;
                    end
                    REG_ALPHA:     alpha_reg <= cfg_val;
                    REG_GAMMA:     gamma_reg <= cfg_val;
                    REG_DECAY:     decay_reg <= cfg_val;
                    REG_EPS_FLOOR: floor_reg <= cfg_val;
                    default:       floor_reg <= floor_reg;
                endcase
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> tb/tabular_q_learning_engine_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tabular_q_learning_engine_core_test
// Drives select/update/decay/read/write requests with random idling and
// stalls on both channels, predicts every response from a private copy of
// the Q table, epsilon and the registers, and compares responses in order.
// ----------------------------------------------------------------------------
module tabular_q_learning_engine_core_test;
    import tqle_pkg::*;

    localparam int N_BOARDS   = 19683;
    localparam int N_ACTIONS  = 9;
    localparam int IDLE_LIMIT = 1000000;  // covers the table clear after reset
    localparam int SETTLE     = 40;
    localparam longint Q_MAX  = 64'sd2147483647;
    localparam longint Q_MIN  = -64'sd2147483648;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    req_t        req;
    logic        rsp_valid;
    logic        rsp_stall;
    rsp_t        rsp;
    logic        cfg_we;
    logic [CFG_IW-1:0] cfg_index;
    logic [CFG_W-1:0]  cfg_wdata;

    // predictor state
    longint      q_table[int];
    longint      eps_now;
    longint      cfg_regs[5];
    rsp_t        expected_rsps[$];

    int          mismatches;
    int          quiet_cycles;
    bit          req_idling;
    bit          rsp_idling;
    bit          hold_start;

    tabular_q_learning_engine_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint sat32(longint v);
        if (v > Q_MAX) return Q_MAX;
        if (v < Q_MIN) return Q_MIN;
        return v;
    endfunction

    // floor(a * f / 2^16)
    function automatic longint scale_q16(longint a, longint f);
        return (a * f) >>> 16;
    endfunction

    function automatic longint table_rd(int key, int a);
        int idx;
        if (key >= N_BOARDS || a >= N_ACTIONS) return 0;
        idx = key * N_ACTIONS + a;
        return q_table.exists(idx) ? q_table[idx] : 0;
    endfunction

    function automatic void table_wr(int key, int a, longint v);
        if (key < N_BOARDS && a < N_ACTIONS) q_table[key * N_ACTIONS + a] = v;
    endfunction

    function automatic void apply_cfg(int index, longint value);
        if (index >= 5) return;
        if (value > ONE_Q16) value = ONE_Q16;
        cfg_regs[index] = value;
        if (index == REG_EPS_INIT) eps_now = value;
    endfunction

    function automatic rsp_t engine_predict(req_t r);
        rsp_t   o;
        int     n_free;
        int     k;
        int     seen;
        bit     have;
        longint best;
        longint v;
        longint target;
        longint cur;
        longint qv;
        o = '0;
        qv = 0;
        n_free = 0;
        for (int a = 0; a < N_ACTIONS; a++) if (r.avail_mask[a]) n_free++;
        case (r.cmd)
            CMD_SELECT:
            begin
                if (n_free == 0) o.status = 1'b1;
                else if (longint'(r.rand_threshold) < eps_now)
                begin
                    k = r.rand_pick % n_free;
                    seen = 0;
                    o.explored = 1'b1;
                    for (int a = 0; a < N_ACTIONS; a++)
                    begin
                        if (!r.avail_mask[a]) continue;
                        if (seen == k)
                        begin
                            o.chosen_action = 4'(a);
                            break;
                        end
                        seen++;
                    end
                    qv = table_rd(r.board_key, o.chosen_action);
                end
                else
                begin
                    have = 0;
                    for (int a = 0; a < N_ACTIONS; a++)
                    begin
                        if (!r.avail_mask[a]) continue;
                        v = table_rd(r.board_key, a);
                        if (!have || v > qv)
                        begin
                            have = 1;
                            qv = v;
                            o.chosen_action = 4'(a);
                        end
                    end
                end
            end
            CMD_UPDATE:
            begin
                if (n_free == 0) o.status = 1'b1;
                else
                begin
                    have = 0;
                    best = 0;
                    for (int a = 0; a < N_ACTIONS; a++)
                    begin
                        if (!r.avail_mask[a]) continue;
                        v = table_rd(r.next_board_key, a);
                        if (!have || v > best)
                        begin
                            have = 1;
                            best = v;
                        end
                    end
                    target = sat32(longint'($signed(r.reward))
                                   + sat32(scale_q16(best, cfg_regs[REG_GAMMA])));
                    cur = table_rd(r.board_key, r.act);
                    qv = sat32(cur + scale_q16(target - cur, cfg_regs[REG_ALPHA]));
                    table_wr(r.board_key, r.act, qv);
                end
            end
            CMD_DECAY:
                if (eps_now >= cfg_regs[REG_EPS_FLOOR])
                    eps_now = (eps_now * cfg_regs[REG_DECAY]) >> 16;
            CMD_READ:
                qv = table_rd(r.board_key, r.act);
            CMD_WRITE:
                table_wr(r.board_key, r.act, longint'($signed(r.q_in)));
            default: ;
        endcase
        o.q_out = 32'(sat32(qv));
        return o;
    endfunction

    // response side: random stalls plus an occasional long hold-off
    initial
    begin
        int hold_left;
        hold_left = 0;
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_start)
            begin
                hold_left = 400;
                hold_start = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= rsp_idling && ($urandom_range(99) < 23);
        end
    end

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsps.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response %p", rsp);
            end
            else
            begin
                want = expected_rsps.pop_front();
                if (rsp.chosen_action !== want.chosen_action || rsp.q_out !== want.q_out
                    || rsp.explored !== want.explored || rsp.status !== want.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp act=%0d q=%0d expl=%0b st=%0b, ",
                                  "got act=%0d q=%0d expl=%0b st=%0b"},
                                 want.chosen_action, want.q_out, want.explored,
                                 want.status, rsp.chosen_action, rsp.q_out,
                                 rsp.explored, rsp.status);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("tabular_q_learning_engine_core_test: FAIL");
            $finish;
        end
    end

    task automatic send_req(input req_t r);
        @(negedge clk);
        while (req_idling && $urandom_range(99) < 23)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        do @(posedge clk); while (req_stall);
        expected_rsps = {expected_rsps, engine_predict(r)};
    endtask

    // drop valid, wait for every response, let the block settle
    task automatic drain;
        @(negedge clk);
        req_valid <= 1'b0;
        while (expected_rsps.size() > 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_cfg(input int index, input int value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_IW'(index);
        cfg_wdata <= CFG_W'(value);
        @(negedge clk);
        cfg_we <= 1'b0;
        apply_cfg(index, value);
    endtask

    function automatic req_t make_req(int cmd, int key, int act, int nkey, int mask,
                                      int rew, int qin, int thr, int pick);
        req_t r;
        r.cmd = 3'(cmd);
        r.board_key = 15'(key);
        r.act = 4'(act);
        r.next_board_key = 15'(nkey);
        r.avail_mask = 9'(mask);
        r.reward = rew;
        r.q_in = qin;
        r.rand_threshold = 16'(thr);
        r.rand_pick = 16'(pick);
        return r;
    endfunction

    function automatic int pick_key();
        int p;
        p = $urandom_range(99);
        if (p < 80) return $urandom_range(15);
        if (p < 90) return $urandom_range(N_BOARDS - 1, N_BOARDS - 4);
        return $urandom_range(32767);
    endfunction

    function automatic int pick_q();
        case ($urandom_range(5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom();
            default: return $signed($urandom_range(8 * 65536)) - 4 * 65536;
        endcase
    endfunction

    function automatic req_t random_req();
        req_t r;
        int   p;
        p = $urandom_range(99);
        r.cmd = 3'((p < 3) ? $urandom_range(7, 5) : (p < 35) ? CMD_SELECT
              : (p < 70) ? CMD_UPDATE : (p < 75) ? CMD_DECAY
              : (p < 87) ? CMD_READ : CMD_WRITE);
        r.board_key = 15'(pick_key());
        r.next_board_key = 15'(pick_key());
        r.act = 4'(($urandom_range(99) < 85) ? $urandom_range(8) : $urandom_range(15));
        p = $urandom_range(99);
        r.avail_mask = 9'((p < 5) ? 9'd0 : (p < 15) ? (9'd1 << $urandom_range(8))
                     : $urandom_range(511));
        r.reward = pick_q();
        r.q_in = pick_q();
        r.rand_threshold = 16'($urandom_range(65535));
        r.rand_pick = 16'($urandom_range(65535));
        return r;
    endfunction

    task automatic run_random(input int n);
        for (int i = 0; i < n; i++) send_req(random_req());
    endtask

    task automatic test_directed;
        // fresh table: greedy ties take the lowest free action
        send_req(make_req(CMD_SELECT, 0, 0, 0, 9'h1f0, 0, 0, 16'hffff, 0));
        send_req(make_req(CMD_SELECT, 0, 0, 0, 9'h000, 0, 0, 0, 0));
        send_req(make_req(CMD_UPDATE, 0, 0, 0, 9'h000, 65536, 0, 0, 0));
        send_req(make_req(CMD_WRITE, 1, 0, 0, 0, 0, 32'h7fffffff, 0, 0));
        send_req(make_req(CMD_WRITE, 1, 8, 0, 0, 0, 32'h80000000, 0, 0));
        send_req(make_req(CMD_READ, 1, 0, 0, 0, 0, 0, 0, 0));
        send_req(make_req(CMD_READ, 1, 8, 0, 0, 0, 0, 0, 0));
        // saturation toward both limits
        send_req(make_req(CMD_UPDATE, 1, 0, 1, 9'h001, 32'h7fffffff, 0, 0, 0));
        send_req(make_req(CMD_UPDATE, 1, 8, 1, 9'h100, 32'h80000000, 0, 0, 0));
        send_req(make_req(CMD_SELECT, 1, 0, 0, 9'h1ff, 0, 0, 16'hffff, 0));
        // explore: pick wraps modulo the free count
        send_req(make_req(CMD_SELECT, 1, 0, 0, 9'h155, 0, 0, 0, 16'hffff));
        send_req(make_req(CMD_SELECT, 1, 0, 0, 9'h1ff, 0, 0, 0, 7));
        // out of range key and action: write dropped, read gives zero
        send_req(make_req(CMD_WRITE, N_BOARDS, 0, 0, 0, 0, 12345, 0, 0));
        send_req(make_req(CMD_READ, N_BOARDS, 0, 0, 0, 0, 0, 0, 0));
        send_req(make_req(CMD_WRITE, 2, 15, 0, 0, 0, 777, 0, 0));
        send_req(make_req(CMD_READ, 2, 9, 0, 0, 0, 0, 0, 0));
        send_req(make_req(CMD_UPDATE, 32767, 15, 32767, 9'h1ff, 65536, 0, 0, 0));
        send_req(make_req(CMD_DECAY, 0, 0, 0, 0, 0, 0, 0, 0));
        send_req(make_req(CMD_SELECT, 3, 0, 0, 9'h1ff, 0, 0, 6500, 3));
        for (int c = 5; c < 8; c++)
            send_req(make_req(c, 1, 0, 1, 9'h1ff, -1, -1, 0, 0));
        send_req(make_req(CMD_UPDATE, N_BOARDS - 1, 8, N_BOARDS - 1, 9'h1ff, -65536,
                          0, 0, 0));
        drain();
    endtask

    task automatic test_cfg_extremes;
        write_cfg(REG_EPS_INIT, ONE_Q16);
        write_cfg(REG_ALPHA, ONE_Q16);
        write_cfg(REG_GAMMA, ONE_Q16);
        write_cfg(REG_DECAY, 131071);      // above one, held as one
        write_cfg(REG_EPS_FLOOR, 0);
        write_cfg(5, 1234);
        write_cfg(7, 0);
        run_random(150);
        drain();
        write_cfg(REG_EPS_INIT, 0);
        write_cfg(REG_ALPHA, 0);
        write_cfg(REG_GAMMA, 0);
        write_cfg(REG_DECAY, 0);
        write_cfg(REG_EPS_FLOOR, ONE_Q16);
        run_random(150);
        drain();
    endtask

    task automatic test_random_phases;
        for (int ph = 0; ph < 5; ph++)
        begin
            for (int i = 0; i < 5; i++)
                write_cfg(i, ($urandom_range(3) == 0) ? $urandom_range(131071)
                                                      : $urandom_range(65536));
            req_idling = (ph != 2);
            rsp_idling = (ph != 2);
            run_random(150);
            drain();
        end
        req_idling = 1;
        rsp_idling = 1;
    endtask

    task automatic test_backpressure;
        write_cfg(REG_EPS_INIT, 32768);
        write_cfg(REG_ALPHA, 32768);
        write_cfg(REG_EPS_FLOOR, 655);
        hold_start = 1;
        req_idling = 0;
        run_random(150);
        req_idling = 1;
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        mismatches = 0;
        quiet_cycles = 0;
        req_idling = 1;
        rsp_idling = 1;
        hold_start = 0;
        cfg_regs[REG_EPS_INIT] = RST_EPS_INIT;
        cfg_regs[REG_ALPHA] = RST_ALPHA;
        cfg_regs[REG_GAMMA] = RST_GAMMA;
        cfg_regs[REG_DECAY] = RST_DECAY;
        cfg_regs[REG_EPS_FLOOR] = RST_EPS_FLOOR;
        eps_now = RST_EPS_INIT;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_cfg_extremes();
        test_random_phases();
        test_backpressure();

        if (mismatches == 0 && expected_rsps.size() == 0)
            $display("tabular_q_learning_engine_core_test: PASS");
        else
            $display("tabular_q_learning_engine_core_test: FAIL");
        $finish;
    end

endmodule
